// ===== rtl/core/jbrq_pkg.sv =====
package jbrq_pkg;

	localparam int TimeW   = 64;
	localparam int CookieW = 32;
	localparam int HandleW = 16;
	localparam int StatusW = 3;
	localparam int OccW    = 7;

	localparam logic CMD_ENQ  = 1'b0;
	localparam logic CMD_POLL = 1'b1;

	localparam logic [StatusW-1:0] ST_STORED   = 3'd0;
	localparam logic [StatusW-1:0] ST_DUP      = 3'd1;
	localparam logic [StatusW-1:0] ST_FULL     = 3'd2;
	localparam logic [StatusW-1:0] ST_RELEASED = 3'd3;
	localparam logic [StatusW-1:0] ST_NONE_DUE = 3'd4;

	typedef struct packed {
		logic               valid;
		logic [TimeW-1:0]   rel;
		logic [TimeW-1:0]   rcv;
		logic [CookieW-1:0] cookie;
		logic [HandleW-1:0] handle;
	} entry_t;

	// shift controls shared by every cell of the row
	typedef struct packed {
		logic ins;
		logic pop;
	} cell_op_t;

	// key order: release time, then receive time, then cookie
	function automatic logic key_lt(input entry_t a, input entry_t b);
		return {a.rel, a.rcv, a.cookie} < {b.rel, b.rcv, b.cookie};
	endfunction

	function automatic logic key_eq(input entry_t a, input entry_t b);
		return {a.rel, a.rcv, a.cookie} == {b.rel, b.rcv, b.cookie};
	endfunction

endpackage

// ===== rtl/core/jbrq_cell.sv =====
module jbrq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  jbrq_pkg::cell_op_t op,
	input  jbrq_pkg::entry_t  ins_e,
	input  jbrq_pkg::entry_t  prev_e,
	input  logic              prev_lt,
	input  jbrq_pkg::entry_t  next_e,
	output jbrq_pkg::entry_t  cur_e,
	output logic              lt,
	output logic              dup
);

	logic             valid_q;
	jbrq_pkg::entry_t data_q;
	jbrq_pkg::entry_t nxt;
	logic             load;

	always_comb begin
		cur_e       = data_q;
		cur_e.valid = valid_q;
	end

	// an empty cell sorts after any key, so the row stays packed at the low end
	assign lt  = !valid_q || jbrq_pkg::key_lt(ins_e, cur_e);
	assign dup = valid_q && jbrq_pkg::key_eq(ins_e, cur_e);

	always_comb begin
		nxt  = cur_e;
		load = 1'b0;
		if (op.ins && lt) begin
			load = 1'b1;
			if (prev_lt) begin
				nxt = prev_e;
			end else begin
				nxt       = ins_e;
				nxt.valid = 1'b1;
			end
		end else if (op.pop) begin
			load = 1'b1;
			nxt  = next_e;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= nxt;
		end
	end

endmodule

// ===== rtl/core/jitter_buffer_release_queue.sv =====
// jitter buffer release queue: holds packet tags sorted by release time
// (rcv_time + delay, wrapping), ties broken by receive time, then cookie.
// input channel in_valid/in_ready carries one request: cmd 0 enqueues,
// cmd 1 polls against now_time. every request gives exactly one result on
// out_valid/out_ready with a status, the released entry (zero unless
// released) and the occupancy after the request.
// storage is a row of CAPACITY cells kept in key order, earliest in cell 0;
// an enqueue shifts later entries up one cell, a release shifts all down.
// an accepted request waits in the request register in front of the cell
// row, which holds one request at a time; the row update then registers the
// result in the output register, and only after it is the next request taken.
// a result waiting in the output register does not block the next request;
// the row update waits only if the output register is still full then.
// reset empties every cell and the occupancy count at once; in_ready is
// high from reset on, so the queue takes requests straight after it.
module jitter_buffer_release_queue #(
	parameter int CAPACITY = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              cmd,
	input  logic [jbrq_pkg::TimeW-1:0]        rcv_time,
	input  logic [jbrq_pkg::TimeW-1:0]        delay,
	input  logic [jbrq_pkg::CookieW-1:0]      cookie,
	input  logic [jbrq_pkg::HandleW-1:0]      handle,
	input  logic [jbrq_pkg::TimeW-1:0]        now_time,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [jbrq_pkg::StatusW-1:0]      status,
	output logic [jbrq_pkg::TimeW-1:0]        out_release_time,
	output logic [jbrq_pkg::TimeW-1:0]        out_rcv_time,
	output logic [jbrq_pkg::CookieW-1:0]      out_cookie,
	output logic [jbrq_pkg::HandleW-1:0]      out_handle,
	output logic [jbrq_pkg::OccW-1:0]         occupancy
);

	localparam int CntW = $clog2(CAPACITY + 1);

	logic                          busy_q;
	logic                          cmd_s1;
	jbrq_pkg::entry_t              req_s1;
	logic [jbrq_pkg::TimeW-1:0]    now_s1;
	logic [CntW-1:0]               count_q;

	logic                          out_valid_q;
	logic [jbrq_pkg::StatusW-1:0]  status_q;
	jbrq_pkg::entry_t              rel_e_q;
	logic [CntW-1:0]               occ_q;
	logic [CntW+jbrq_pkg::OccW-1:0] occ_ext;

	jbrq_pkg::entry_t              cell_e [CAPACITY];
	logic [CAPACITY-1:0]           lt_vec;
	logic [CAPACITY-1:0]           dup_vec;
	jbrq_pkg::cell_op_t            op;

	logic                          go;
	logic                          any_dup;
	logic                          full;
	logic                          due;
	logic                          in_acc;
	logic [jbrq_pkg::StatusW-1:0]  status_d;
	logic [CntW-1:0]               count_d;

	assign in_ready = !busy_q;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
		end else if (go) begin
			busy_q <= 1'b0;
		end
	end

	// request register; release time formed here so the row sees a plain key
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1        <= cmd;
			req_s1.valid  <= 1'b1;
			req_s1.rel    <= rcv_time + delay;
			req_s1.rcv    <= rcv_time;
			req_s1.cookie <= cookie;
			req_s1.handle <= handle;
			now_s1        <= now_time;
		end
	end

	assign go      = busy_q && (!out_valid_q || out_ready);
	assign any_dup = |dup_vec;
	assign full    = (count_q == CntW'(CAPACITY));
	assign due     = cell_e[0].valid && (cell_e[0].rel <= now_s1);

	always_comb begin
		op       = '0;
		count_d  = count_q;
		status_d = jbrq_pkg::ST_NONE_DUE;
		if (cmd_s1 == jbrq_pkg::CMD_ENQ) begin
			if (any_dup) begin
				status_d = jbrq_pkg::ST_DUP;
			end else if (full) begin
				status_d = jbrq_pkg::ST_FULL;
			end else begin
				status_d = jbrq_pkg::ST_STORED;
				op.ins   = go;
				count_d  = count_q + CntW'(1);
			end
		end else if (due) begin
			status_d = jbrq_pkg::ST_RELEASED;
			op.pop   = go;
			count_d  = count_q - CntW'(1);
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			jbrq_pkg::entry_t prev_e;
			jbrq_pkg::entry_t next_e;
			logic             prev_lt;
			if (gi == 0) begin : g_first
				assign prev_e  = '0;
				assign prev_lt = 1'b0;
			end else begin : g_mid
				assign prev_e  = cell_e[gi-1];
				assign prev_lt = lt_vec[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_last
				assign next_e = '0;
			end else begin : g_inner
				assign next_e = cell_e[gi+1];
			end
			jbrq_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.op      (op),
				.ins_e   (req_s1),
				.prev_e  (prev_e),
				.prev_lt (prev_lt),
				.next_e  (next_e),
				.cur_e   (cell_e[gi]),
				.lt      (lt_vec[gi]),
				.dup     (dup_vec[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			status_q <= status_d;
			occ_q    <= count_d;
			if (status_d == jbrq_pkg::ST_RELEASED) begin
				rel_e_q <= cell_e[0];
			end else begin
				rel_e_q <= '0;
			end
		end
	end

	assign occ_ext = (CntW + jbrq_pkg::OccW)'(occ_q);

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign out_release_time = rel_e_q.rel;
	assign out_rcv_time     = rel_e_q.rcv;
	assign out_cookie       = rel_e_q.cookie;
	assign out_handle       = rel_e_q.handle;
	assign occupancy        = occ_ext[jbrq_pkg::OccW-1:0];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(CAPACITY))
		else $error("entry count above capacity");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		cell_e[0].valid == (count_q != '0))
		else $error("head cell valid disagrees with entry count");

	a_store_counts_up: assert property (@(posedge clk) disable iff (!arst_n)
		op.ins |=> count_q == $past(count_q) + CntW'(1))
		else $error("store did not raise entry count");

	a_release_due: assert property (@(posedge clk) disable iff (!arst_n)
		op.pop |-> cell_e[0].valid && cell_e[0].rel <= now_s1)
		else $error("release of an entry that is not due");

endmodule

// ===== verif/jitter_buffer_release_queue_tb.sv =====
module jitter_buffer_release_queue_tb;

	localparam int CAP        = 64;
	localparam int N_ITEMS    = 1925;
	localparam int MAX_CYCLES = 500000;

	typedef struct {
		logic                         cmd;
		logic [jbrq_pkg::TimeW-1:0]   rcv;
		logic [jbrq_pkg::TimeW-1:0]   dly;
		logic [jbrq_pkg::CookieW-1:0] ck;
		logic [jbrq_pkg::HandleW-1:0] hd;
		logic [jbrq_pkg::TimeW-1:0]   now;
		bit                           drain;
	} req_t;

	typedef struct {
		logic [jbrq_pkg::StatusW-1:0] status;
		logic [jbrq_pkg::TimeW-1:0]   rel;
		logic [jbrq_pkg::TimeW-1:0]   rcv;
		logic [jbrq_pkg::CookieW-1:0] ck;
		logic [jbrq_pkg::HandleW-1:0] hd;
		logic [jbrq_pkg::OccW-1:0]    occ;
	} outcome_t;

	typedef struct {
		logic [jbrq_pkg::TimeW-1:0]   rcv;
		logic [jbrq_pkg::TimeW-1:0]   dly;
		logic [jbrq_pkg::CookieW-1:0] ck;
	} key_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	logic                         cmd = jbrq_pkg::CMD_ENQ;
	logic [jbrq_pkg::TimeW-1:0]   rcv_time = '0;
	logic [jbrq_pkg::TimeW-1:0]   delay = '0;
	logic [jbrq_pkg::CookieW-1:0] cookie = '0;
	logic [jbrq_pkg::HandleW-1:0] handle = '0;
	logic [jbrq_pkg::TimeW-1:0]   now_time = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic [jbrq_pkg::StatusW-1:0] status;
	logic [jbrq_pkg::TimeW-1:0]   out_release_time;
	logic [jbrq_pkg::TimeW-1:0]   out_rcv_time;
	logic [jbrq_pkg::CookieW-1:0] out_cookie;
	logic [jbrq_pkg::HandleW-1:0] out_handle;
	logic [jbrq_pkg::OccW-1:0]    occupancy;

	jitter_buffer_release_queue DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.cmd              (cmd),
		.rcv_time         (rcv_time),
		.delay            (delay),
		.cookie           (cookie),
		.handle           (handle),
		.now_time         (now_time),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.out_release_time (out_release_time),
		.out_rcv_time     (out_rcv_time),
		.out_cookie       (out_cookie),
		.out_handle       (out_handle),
		.occupancy        (occupancy)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	req_t     req_q[$];
	outcome_t outcome_q[$];
	key_t     key_hist[$];
	bit       want_drain;
	int       n_acc = 0;
	int       n_done = 0;
	int       n_err = 0;
	int       cycles = 0;

	// shadow of the held entries
	logic [jbrq_pkg::TimeW-1:0]   held_rel [CAP];
	logic [jbrq_pkg::TimeW-1:0]   held_rcv [CAP];
	logic [jbrq_pkg::CookieW-1:0] held_ck [CAP];
	logic [jbrq_pkg::HandleW-1:0] held_hd [CAP];
	bit                           held_v [CAP];
	int                           held_n = 0;

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t: %s: got %h expected %h", $time, what, got, want);
		n_err++;
	endtask

	// applies one request to the shadow store and returns its outcome
	task automatic release_queue_step(input req_t r, output outcome_t o);
		logic [jbrq_pkg::TimeW-1:0] rel;
		int                         slot;
		int                         best;
		bit                         dup;
		o = '{default: '0};
		if (r.cmd == jbrq_pkg::CMD_ENQ) begin
			rel = r.rcv + r.dly;
			slot = -1;
			dup = 1'b0;
			for (int i = 0; i < CAP; i++) begin
				if (held_v[i]) begin
					if ({held_rel[i], held_rcv[i], held_ck[i]} == {rel, r.rcv, r.ck})
						dup = 1'b1;
				end else if (slot < 0) begin
					slot = i;
				end
			end
			if (dup) begin
				o.status = jbrq_pkg::ST_DUP;
			end else if (held_n >= CAP || slot < 0) begin
				o.status = jbrq_pkg::ST_FULL;
			end else begin
				held_rel[slot] = rel;
				held_rcv[slot] = r.rcv;
				held_ck[slot] = r.ck;
				held_hd[slot] = r.hd;
				held_v[slot] = 1'b1;
				held_n++;
				o.status = jbrq_pkg::ST_STORED;
			end
		end else begin
			best = -1;
			for (int i = 0; i < CAP; i++) begin
				if (held_v[i] && (best < 0 || {held_rel[i], held_rcv[i], held_ck[i]} <
						{held_rel[best], held_rcv[best], held_ck[best]}))
					best = i;
			end
			if (best >= 0 && held_rel[best] <= r.now) begin
				o.status = jbrq_pkg::ST_RELEASED;
				o.rel = held_rel[best];
				o.rcv = held_rcv[best];
				o.ck = held_ck[best];
				o.hd = held_hd[best];
				held_v[best] = 1'b0;
				held_n--;
			end else begin
				o.status = jbrq_pkg::ST_NONE_DUE;
			end
		end
		o.occ = held_n[jbrq_pkg::OccW-1:0];
	endtask

	task automatic add_enq(input logic [jbrq_pkg::TimeW-1:0] rcv,
			input logic [jbrq_pkg::TimeW-1:0] dly,
			input logic [jbrq_pkg::CookieW-1:0] ck, input logic [jbrq_pkg::HandleW-1:0] hd);
		req_t r;
		key_t k;
		r = '{cmd: jbrq_pkg::CMD_ENQ, rcv: rcv, dly: dly, ck: ck, hd: hd,
			now: {$urandom, $urandom}, drain: want_drain || $urandom_range(0, 149) == 0};
		want_drain = 1'b0;
		req_q.push_back(r);
		k = '{rcv: rcv, dly: dly, ck: ck};
		key_hist.push_back(k);
		if (key_hist.size() > 80)
			void'(key_hist.pop_front());
	endtask

	task automatic add_poll(input logic [jbrq_pkg::TimeW-1:0] now);
		req_t r;
		r = '{cmd: jbrq_pkg::CMD_POLL, rcv: {$urandom, $urandom}, dly: {$urandom, $urandom},
			ck: $urandom, hd: 16'($urandom), now: now,
			drain: want_drain || $urandom_range(0, 149) == 0};
		want_drain = 1'b0;
		req_q.push_back(r);
	endtask

	task automatic add_old_key();
		key_t k;
		k = key_hist[$urandom_range(0, key_hist.size() - 1)];
		add_enq(k.rcv, k.dly, k.ck, 16'($urandom));
	endtask

	// stimulus
	initial begin
		logic [jbrq_pkg::TimeW-1:0] t;
		int                         n;
		int                         pick;
		int                         n_total;

		// empty polls at both ends of time
		add_poll('0);
		add_poll('1);
		add_enq('0, '0, '0, '0);
		// same key, other handle
		add_enq('0, '0, '0, '1);
		// release time wraps to 1
		add_enq('1, 64'd2, '1, '1);
		add_enq(64'd1, '0, '0, 16'h5a5a);
		// cookie tie at the sign bit
		add_enq(64'd5, 64'd5, 32'h8000_0000, 16'h0001);
		add_enq(64'd5, 64'd5, 32'h7fff_ffff, 16'h0002);
		add_enq(64'd10, '0, '0, 16'h0003);
		add_enq(64'd3, 64'd7, '0, 16'h0004);
		add_poll('0);
		add_poll('0);
		add_poll(64'd9);
		add_poll(64'd9);
		add_poll(64'd9);
		for (int i = 0; i < 4; i++)
			add_poll('1);
		add_poll('1);
		add_enq('0, '1, 32'h1234_5678, 16'hbeef);
		add_poll(64'hffff_ffff_ffff_fffe);
		add_poll('1);

		// fill past capacity once, with a repeated key while full
		want_drain = 1'b1;
		for (int i = 0; i < 70; i++)
			add_enq({$urandom, $urandom}, {$urandom, $urandom}, $urandom, 16'($urandom));
		add_enq(key_hist[10].rcv, key_hist[10].dly, key_hist[10].ck, 16'($urandom));
		for (int i = 0; i < 66; i++)
			add_poll('1);

		t = {$urandom, $urandom};
		while (req_q.size() < N_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// traffic around a moving clock, sometimes next to the wrap
				if ($urandom_range(0, 3) == 0)
					t = 64'hffff_ffff_ffff_ffff - 64'($urandom_range(0, 200));
				n = $urandom_range(10, 40);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 9) < 6)
						add_enq(t + 64'($urandom_range(0, 20)), 64'($urandom_range(0, 50)),
							($urandom_range(0, 1) ? 32'hffff_fffc : 32'h0) |
							$urandom_range(0, 3), 16'($urandom));
					else
						add_poll(t + 64'($urandom_range(0, 60)));
					t = t + 64'($urandom_range(0, 10));
				end
			end else if (pick < 75) begin
				n = $urandom_range(40, 70);
				for (int i = 0; i < n; i++)
					add_enq({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
						16'($urandom));
				add_old_key();
				for (int i = 0; i < n + 3; i++)
					add_poll('1);
			end else if (pick < 90) begin
				for (int i = 0; i < 10; i++) begin
					if ($urandom_range(0, 1))
						add_enq({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
							16'($urandom));
					else
						add_poll({$urandom, $urandom});
				end
			end else begin
				for (int i = 0; i < 5; i++)
					add_old_key();
			end
		end
		n_total = req_q.size();

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		while (n_done != n_total)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (outcome_q.size() != 0)
			flag_mismatch("results never delivered", 64'(outcome_q.size()), 64'd0);
		if (n_err == 0)
			$display("[jitter_buffer_release_queue] OK");
		else
			$display("[jitter_buffer_release_queue] ERROR");
		$finish;
	end

	// request driver
	int   burst_left;
	int   gap_left;
	bit   drv_took;
	req_t drv_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			drv_took = in_valid && in_ready;
			if (!in_valid || drv_took) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (req_q.size() != 0 &&
						!(req_q[0].drain && (drv_took || n_acc != n_done))) begin
					drv_next = req_q.pop_front();
					cmd <= drv_next.cmd;
					rcv_time <= drv_next.rcv;
					delay <= drv_next.dly;
					cookie <= drv_next.ck;
					handle <= drv_next.hd;
					now_time <= drv_next.now;
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 20);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor, prediction and receiver stalls
	int       stall_mode;
	int       mode_left;
	logic [7:0] stall_pat;
	outcome_t want;
	outcome_t fresh;
	req_t     seen_req;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_mode <= 0;
			mode_left <= 0;
			stall_pat <= 8'h01;
		end else begin
			if (out_valid && out_ready) begin
				if (outcome_q.size() == 0) begin
					flag_mismatch("result with no request pending", 64'(status), 64'd0);
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.status)
						flag_mismatch("status", 64'(status), 64'(want.status));
					if (out_release_time !== want.rel)
						flag_mismatch("out_release_time", out_release_time, want.rel);
					if (out_rcv_time !== want.rcv)
						flag_mismatch("out_rcv_time", out_rcv_time, want.rcv);
					if (out_cookie !== want.ck)
						flag_mismatch("out_cookie", 64'(out_cookie), 64'(want.ck));
					if (out_handle !== want.hd)
						flag_mismatch("out_handle", 64'(out_handle), 64'(want.hd));
					if (occupancy !== want.occ)
						flag_mismatch("occupancy", 64'(occupancy), 64'(want.occ));
					n_done <= n_done + 1;
				end
			end
			if (in_valid && in_ready) begin
				seen_req = '{cmd: cmd, rcv: rcv_time, dly: delay, ck: cookie, hd: handle,
					now: now_time, drain: 1'b0};
				release_queue_step(seen_req, fresh);
				outcome_q.push_back(fresh);
				n_acc <= n_acc + 1;
			end
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left <= $urandom_range(20, 200);
				stall_pat <= 8'($urandom) | 8'h01;
				out_ready <= 1'b1;
			end else begin
				mode_left <= mode_left - 1;
				case (stall_mode)
					0: begin
						out_ready <= 1'b1;
					end
					1: begin
						out_ready <= 1'($urandom_range(0, 1));
					end
					2: begin
						out_ready <= ($urandom_range(0, 3) == 0);
					end
					default: begin
						out_ready <= stall_pat[0];
						stall_pat <= {stall_pat[0], stall_pat[7:1]};
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("[jitter_buffer_release_queue] ERROR");
			$finish;
		end
	end

endmodule
